>>> rtl/keyed_crc_signature_defines.svh
// Assertion macros for the keyed CRC signature block.
// KCS_ASSERT checks at the clock edge outside of reset.
// KCS_ASSERT_RST checks at the clock edge, reset included.
`ifndef KEYED_CRC_SIGNATURE_DEFINES_SVH
`define KEYED_CRC_SIGNATURE_DEFINES_SVH

`ifndef SYNTHESIS
`define KCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KCS_ASSERT(lbl, prop, msg)
`define KCS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/kcs_pkg.sv
`default_nettype none

package kcs_pkg;

  localparam int unsigned NUM_BYTES = 16;
  localparam int unsigned IDX_W     = $clog2(NUM_BYTES);
  localparam int unsigned CRC_W     = 32;
  localparam int unsigned CFG_W     = 64;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BYTES - 1);

  typedef enum logic [1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_PARAM_LOW  = 2'd2,
    CFG_PARAM_HIGH = 2'd3
  } kcs_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CRC,
    ST_FIN,
    ST_DONE
  } kcs_state_e;

  // control of the shared CRC unit
  typedef struct packed {
    logic load;  // state <= load value
    logic step;  // state <= CRC of state and one byte
  } kcs_crc_ctl_t;

endpackage

`default_nettype wire

>>> rtl/kcs_crc_unit.sv
`default_nettype none

// Running CRC-32 state, reflected, one byte per step.
module kcs_crc_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire kcs_pkg::kcs_crc_ctl_t        ctl_i,
  input  wire logic [kcs_pkg::CRC_W-1:0]    load_val_i,
  input  wire logic [7:0]                   byte_i,
  output logic      [kcs_pkg::CRC_W-1:0]    crc_o
);

  logic [kcs_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [kcs_pkg::CRC_W-1:0] stepped;

  always_comb begin
    logic [kcs_pkg::CRC_W-1:0] t;
    t = {24'd0, crc_q[7:0] ^ byte_i};
    for (int b = 0; b < 8; b++) begin
      if (t[0]) begin
        t = (t >> 1) ^ kcs_pkg::CRC_POLY;
      end else begin
        t = t >> 1;
      end
    end
    stepped = t ^ (crc_q >> 8);
  end

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.load) begin
      crc_d = load_val_i;
    end else if (ctl_i.step) begin
      crc_d = stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

>>> rtl/keyed_crc_signature.sv
// keyed_crc_signature: 16-byte challenge in, 16-byte keyed CRC-32 signature out.
// Input channel: challenge_low/high_i and unlock_byte_i move on in_valid_i with
//   in_stall_o low. in_stall_o is high whenever an item is being worked.
// Output channel: signature_low/high_o move on out_valid_o with out_stall_i low.
// Config: cfg_we_i writes cfg_wdata_i to key_low, key_high, param_low or
//   param_high (cfg_idx_i 0..3). The user must write only while the block is
//   idle; the block itself does not enforce it.
// Schedule: one byte-wide CRC unit is reused for all 256 byte steps. Each of the
//   16 rounds does a work byte update, 16 CRC byte steps and an unlock add; the
//   result then goes to the output register before the next item is taken.
// The result sits in its own output register, so a new item can start while
//   the previous signature waits. If the receiver still stalls the old result
//   when the new one is done, the block holds the new one until the slot frees.
// Reset: key and parameter registers clear to zero, no result is pending, the
//   block is idle and ready.
`default_nettype none
`include "keyed_crc_signature_defines.svh"

module keyed_crc_signature (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] challenge_low_i,
  input  wire logic [63:0] challenge_high_i,
  input  wire logic [7:0]  unlock_byte_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      signature_low_o,
  output logic [63:0]      signature_high_o
);

  localparam int unsigned NB = kcs_pkg::NUM_BYTES;
  localparam int unsigned IW = kcs_pkg::IDX_W;

  // config registers
  logic [63:0] key_low_q, key_high_q, param_low_q, param_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      param_low_q  <= '0;
      param_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kcs_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_wdata_i;
        kcs_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_wdata_i;
        kcs_pkg::CFG_PARAM_LOW:  param_low_q  <= cfg_wdata_i;
        kcs_pkg::CFG_PARAM_HIGH: param_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // byte views, byte 0 in the low bits
  logic [NB-1:0][7:0] key_b, param_b, chal_b;
  assign key_b   = {key_high_q, key_low_q};
  assign param_b = {param_high_q, param_low_q};
  assign chal_b  = {challenge_high_i, challenge_low_i};

  // sequencer state
  kcs_pkg::kcs_state_e state_q, state_d;
  logic [IW-1:0]       round_q, round_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [7:0]          unlock_q, unlock_d;
  logic [NB-1:0][7:0]  work_q, work_d;
  logic [NB-1:0][7:0]  sig_q, sig_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         sig_low_q, sig_low_d, sig_high_q, sig_high_d;

  logic                  in_xfer, out_free;
  logic [IW-1:0]         rd_addr;
  logic [7:0]            work_rd;
  logic [31:0]           crc;
  logic [31:0]           crc_plus;
  logic [7:0]            sig_byte;
  kcs_pkg::kcs_crc_ctl_t crc_ctl;
  logic [31:0]           crc_load;

  assign in_stall_o = (state_q != kcs_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // one read port on the work bytes: the round byte while updating it,
  // otherwise the byte the CRC is consuming
  assign rd_addr  = (state_q == kcs_pkg::ST_PREP) ? round_q : idx_q;
  assign work_rd  = work_q[rd_addr];

  assign crc_plus = crc + {24'd0, unlock_q};
  assign sig_byte = crc_plus[7:0] + crc_plus[15:8];

  kcs_crc_unit u_crc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (crc_ctl),
    .load_val_i (crc_load),
    .byte_i     (work_rd),
    .crc_o      (crc)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kcs_pkg::ST_IDLE: if (in_xfer) state_d = kcs_pkg::ST_PREP;
      kcs_pkg::ST_PREP: state_d = kcs_pkg::ST_CRC;
      kcs_pkg::ST_CRC:  if (idx_q == kcs_pkg::LAST_IDX) state_d = kcs_pkg::ST_FIN;
      kcs_pkg::ST_FIN: begin
        state_d = (round_q == kcs_pkg::LAST_IDX) ? kcs_pkg::ST_DONE : kcs_pkg::ST_PREP;
      end
      kcs_pkg::ST_DONE: if (out_free) state_d = kcs_pkg::ST_IDLE;
      default:          state_d = kcs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    round_d     = round_q;
    idx_d       = idx_q;
    unlock_d    = unlock_q;
    work_d      = work_q;
    sig_d       = sig_q;
    sig_low_d   = sig_low_q;
    sig_high_d  = sig_high_q;
    out_valid_d = out_valid_q && out_stall_i;
    crc_ctl     = '0;
    crc_load    = '0;
    unique case (state_q)
      kcs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          for (int i = 0; i < NB; i++) begin
            work_d[i] = key_b[i] + chal_b[i] + param_b[i];
          end
          unlock_d     = unlock_byte_i;
          round_d      = '0;
          crc_ctl.load = 1'b1;  // running value restarts at zero
        end
      end
      kcs_pkg::ST_PREP: begin
        work_d[round_q] = work_rd + (key_b[round_q] ^ crc[7:0]);
        idx_d = '0;
      end
      kcs_pkg::ST_CRC: begin
        crc_ctl.step = 1'b1;
        idx_d        = idx_q + 1'b1;
      end
      kcs_pkg::ST_FIN: begin
        crc_ctl.load   = 1'b1;
        crc_load       = crc_plus;
        sig_d[round_q] = sig_byte;
        round_d        = round_q + 1'b1;
      end
      kcs_pkg::ST_DONE: begin
        if (out_free) begin
          sig_low_d   = sig_q[NB/2-1:0];
          sig_high_d  = sig_q[NB-1:NB/2];
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kcs_pkg::ST_IDLE;
      round_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unlock_q   <= unlock_d;
    work_q     <= work_d;
    sig_q      <= sig_d;
    sig_low_q  <= sig_low_d;
    sig_high_q <= sig_high_d;
  end

  assign out_valid_o      = out_valid_q;
  assign signature_low_o  = sig_low_q;
  assign signature_high_o = sig_high_q;

  `KCS_ASSERT(a_accept_starts, in_xfer |=> state_q == kcs_pkg::ST_PREP,
    "accepted item did not start")
  `KCS_ASSERT(a_crc_pass_ends,
    (state_q == kcs_pkg::ST_CRC) && (idx_q == kcs_pkg::LAST_IDX) |=> state_q == kcs_pkg::ST_FIN,
    "CRC pass overran")
  `KCS_ASSERT(a_last_round,
    (state_q == kcs_pkg::ST_FIN) && (round_q == kcs_pkg::LAST_IDX)
      |=> state_q == kcs_pkg::ST_DONE,
    "missed end of rounds")
  `KCS_ASSERT(a_done_delivers,
    (state_q == kcs_pkg::ST_DONE) && out_free |=> out_valid_o && (state_q == kcs_pkg::ST_IDLE),
    "result not delivered")
  `KCS_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o && !in_stall_o, "busy during reset")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int unsigned DRAIN_WAIT  = 300;   // roughly one item's latency
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned RAND_ITEMS  = 180;   // per phase

  // Expected-signature store with its own copy of the key/param registers.
  class signature_predictor;
    logic [63:0]  regs [4];
    logic [127:0] expected_sigs [$];
    int unsigned  errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(kcs_pkg::kcs_cfg_e idx, logic [63:0] data);
      regs[int'(idx)] = data;
    endfunction

    function int unsigned pending();
      return expected_sigs.size();
    endfunction

    // Work out the signature of one accepted challenge.
    function void note_challenge(logic [63:0] ch_lo, logic [63:0] ch_hi, logic [7:0] unlock);
      logic [127:0] key_all, par_all, ch_all, sig;
      logic [7:0]   work [16];
      logic [7:0]   key_b [16];
      logic [31:0]  run, t;
      key_all = {regs[int'(kcs_pkg::CFG_KEY_HIGH)], regs[int'(kcs_pkg::CFG_KEY_LOW)]};
      par_all = {regs[int'(kcs_pkg::CFG_PARAM_HIGH)], regs[int'(kcs_pkg::CFG_PARAM_LOW)]};
      ch_all  = {ch_hi, ch_lo};
      sig     = '0;
      for (int i = 0; i < 16; i++) begin
        key_b[i] = key_all[i*8 +: 8];
        work[i]  = key_b[i] + ch_all[i*8 +: 8] + par_all[i*8 +: 8];
      end
      run = '0;
      for (int i = 0; i < 16; i++) begin
        work[i] = work[i] + (key_b[i] ^ run[7:0]);
        // reflected CRC-32 over all work bytes, seeded with the running value
        for (int j = 0; j < 16; j++) begin
          t = {24'd0, run[7:0] ^ work[j]};
          for (int b = 0; b < 8; b++) begin
            if (t[0]) begin
              t = kcs_pkg::CRC_POLY ^ (t >> 1);
            end else begin
              t = t >> 1;
            end
          end
          run = t ^ (run >> 8);
        end
        run = run + {24'd0, unlock};
        sig[i*8 +: 8] = run[7:0] + run[15:8];
      end
      expected_sigs.push_back(sig);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) begin
        $display("tb: mismatch %s expected %h actual %h", field, want, got);
      end
    endfunction

    function void check_signature(logic [63:0] sig_lo, logic [63:0] sig_hi);
      logic [127:0] want;
      if (expected_sigs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: unexpected signature %h %h", sig_hi, sig_lo);
        end
      end else begin
        want = expected_sigs.pop_front();
        if (sig_lo !== want[63:0]) report("signature_low", want[63:0], sig_lo);
        if (sig_hi !== want[127:64]) report("signature_high", want[127:64], sig_hi);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] challenge_low_i = '0;
  logic [63:0] challenge_high_i = '0;
  logic [7:0]  unlock_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] signature_low_o;
  logic [63:0] signature_high_o;

  int unsigned idle_pct  = 0;  // sender idle chance per cycle
  int unsigned stall_pct = 0;  // receiver stall chance per cycle
  int unsigned quiet_cycles = 0;

  signature_predictor sigs = new();

  keyed_crc_signature dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .challenge_low_i (challenge_low_i),
    .challenge_high_i(challenge_high_i),
    .unlock_byte_i   (unlock_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .signature_low_o (signature_low_o),
    .signature_high_o(signature_high_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stall, one draw per cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: predict on each input transfer, check each output transfer,
  // and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sigs.note_challenge(challenge_low_i, challenge_high_i, unlock_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sigs.check_signature(signature_low_o, signature_high_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one challenge, with random idle cycles in front, and hold it until
  // the transfer. Returns in the step of the accepting edge.
  task automatic send_challenge(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [7:0] unlock);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    challenge_low_i  <= lo;
    challenge_high_i <= hi;
    unlock_byte_i    <= unlock;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Write all four registers on back-to-back edges; block must be idle.
  task automatic load_regs(input logic [63:0] k_lo, input logic [63:0] k_hi,
                           input logic [63:0] p_lo, input logic [63:0] p_hi);
    logic [63:0]       vals [4];
    kcs_pkg::kcs_cfg_e idx;
    vals[0] = k_lo;
    vals[1] = k_hi;
    vals[2] = p_lo;
    vals[3] = p_hi;
    idx = kcs_pkg::CFG_KEY_LOW;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[i];
      sigs.set_reg(idx, vals[i]);
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly random, sometimes an extreme.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // idling pattern cycles through: none, sender, receiver, both
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase

      // registers only change with nothing in flight
      case (ph)
        0: ;  // keep reset values
        1: load_regs('1, '1, '1, '1);
        2: load_regs('1, '1, '0, '0);
        3: load_regs('0, '0, '1, '1);
        7: load_regs('0, '0, '0, '0);
        default: load_regs({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase

      if (ph == 0) begin
        // field extremes and bit patterns under zero key/param
        send_challenge('0, '0, 8'h00);
        send_challenge('1, '1, 8'hFF);
        send_challenge('1, '0, 8'h00);
        send_challenge('0, '1, 8'hFF);
        send_challenge('0, '0, 8'hFF);
        send_challenge('0, '0, 8'h01);
        send_challenge(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'hAA);
        send_challenge(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
        send_challenge(64'h1, 64'h0, 8'h80);
        send_challenge(64'h0, 64'h8000_0000_0000_0000, 8'h7F);
        send_challenge(64'h8000_0000_0000_0000, 64'h1, 8'h00);
        send_challenge(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 8'h5A);
        send_challenge(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 8'hC3);
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
        send_challenge(pick_word(), pick_word(), 8'($urandom_range(255)));
      end
      in_valid_i <= 1'b0;

      // drain before the next register set
      @(posedge clk_i);
      while (sigs.pending() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sigs.errors == 0 && sigs.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
